FILE: rtl/upr_pkg.sv
`default_nettype none

package upr_pkg;

    // number formats
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;
    localparam int RATIO_W   = 20;
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(13107);

    // radicand: p*p plus or minus ratio*|p-o|, one bit of headroom for the sum
    localparam int PROD_W = (2 * VAL_W > RATIO_W + VAL_W) ? 2 * VAL_W : RATIO_W + VAL_W;
    localparam int RAD_W  = PROD_W + 1;
    // signed accumulator
    localparam int ACC_W  = RAD_W + 1;

    // root: one result bit per pair of radicand bits
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int PAIR_W = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;

    localparam int MUL_CNT_W  = $clog2(VAL_W + 1);
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROOT,
        ST_DONE
    } upr_state_t;

endpackage

`default_nettype wire

FILE: rtl/upr_mac.sv
`default_nettype none

// Bit-serial radicand: acc = p*p +/- ratio*|p-o|, one multiplier bit per cycle,
// MSB first (Horner form).
module upr_mac (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 start,
    input  wire logic [upr_pkg::VAL_W-1:0]            prior_new,
    input  wire logic [upr_pkg::VAL_W-1:0]            prior_old,
    input  wire logic [upr_pkg::RATIO_W-1:0]          ratio,
    output logic                                      done,
    output logic signed [upr_pkg::ACC_W-1:0]          acc
);

    logic [upr_pkg::VAL_W-1:0]           mcand_reg;
    logic [upr_pkg::VAL_W-1:0]           pbits_reg;
    logic [upr_pkg::VAL_W-1:0]           dbits_reg;
    logic                                sub_reg;
    logic signed [upr_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [upr_pkg::MUL_CNT_W-1:0]       cnt_reg;
    logic                                busy_reg;
    logic                                done_reg;

    logic [upr_pkg::ACC_W-1:0]           term_p;
    logic [upr_pkg::ACC_W-1:0]           term_r;
    logic [upr_pkg::VAL_W-1:0]           diff;
    logic                                p_ge_o;

    assign p_ge_o = (prior_new >= prior_old);
    assign diff   = p_ge_o ? (prior_new - prior_old) : (prior_old - prior_new);

    always_comb begin
        term_p = pbits_reg[upr_pkg::VAL_W-1] ? upr_pkg::ACC_W'(mcand_reg) : '0;
        term_r = dbits_reg[upr_pkg::VAL_W-1] ? upr_pkg::ACC_W'(ratio) : '0;
        if (sub_reg) begin
            acc_next = {acc_reg[upr_pkg::ACC_W-2:0], 1'b0} + term_p - term_r;
        end else begin
            acc_next = {acc_reg[upr_pkg::ACC_W-2:0], 1'b0} + term_p + term_r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= upr_pkg::MUL_CNT_W'(upr_pkg::VAL_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == upr_pkg::MUL_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= prior_new;
            pbits_reg <= prior_new;
            dbits_reg <= diff;
            sub_reg   <= p_ge_o;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            pbits_reg <= {pbits_reg[upr_pkg::VAL_W-2:0], 1'b0};
            dbits_reg <= {dbits_reg[upr_pkg::VAL_W-2:0], 1'b0};
            acc_reg   <= acc_next;
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/upr_sqrt.sv
`default_nettype none

// Bit-serial floor square root: two radicand bits in, one root bit out per cycle.
module upr_sqrt (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [upr_pkg::RAD_W-1:0]         rad,
    output logic                                   done,
    output logic [upr_pkg::ROOT_W-1:0]             root
);

    logic [upr_pkg::PAIR_W-1:0]      rad_sh_reg;
    logic [upr_pkg::REM_W-1:0]       rem_reg;
    logic [upr_pkg::ROOT_W-1:0]      root_reg;
    logic [upr_pkg::ROOT_CNT_W-1:0]  cnt_reg;
    logic                            busy_reg;
    logic                            done_reg;

    logic [upr_pkg::REM_W-1:0]       rem_shift;
    logic [upr_pkg::REM_W-1:0]       trial;
    logic                            fits;

    always_comb begin
        rem_shift = {rem_reg[upr_pkg::REM_W-3:0],
                     rad_sh_reg[upr_pkg::PAIR_W-1:upr_pkg::PAIR_W-2]};
        trial     = upr_pkg::REM_W'({root_reg, 2'b01});
        fits      = (rem_shift >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= upr_pkg::ROOT_CNT_W'(upr_pkg::ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == upr_pkg::ROOT_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_sh_reg <= upr_pkg::PAIR_W'(rad);
            rem_reg    <= '0;
            root_reg   <= '0;
        end else if (busy_reg) begin
            rad_sh_reg <= {rad_sh_reg[upr_pkg::PAIR_W-3:0], 2'b00};
            if (fits) begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[upr_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[upr_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

FILE: rtl/burgers_upwind_row_step.sv
`default_nettype none

// One row of an implicit upwind step for the inviscid Burgers equation.
// Input channel (s_valid/s_ready): one grid point per item, old level in
// unsigned Q1.16 plus row start/end markers. Output channel (m_valid/m_ready):
// new level, last-point marker and a clamp flag, one item per input item,
// in order.
// Boundary points (either marker) copy the old value through the done state to
// the output register. Inner points: sqrt(pn^2 - ratio*(pn - po)) from the
// previous point, in order: bit-serial multiply, one bit of the 17-bit value
// per cycle; handoff; bit-serial root, one root bit per cycle, 19 bits; result
// latch; output load. One item is in work at a time; s_ready is high only
// while the core is idle.
// The output register holds a finished item while the next one computes; if
// the receiver stalls, the core waits in its done state until the slot frees.
// cfg_wr_en/cfg_wr_data write step_ratio (Q4.16); the user must write it only
// while idle; the block does not enforce it. Reset (aresetn, synchronous):
// ratio = 0.2, previous-point state = 0, output empty.
module burgers_upwind_row_step (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [upr_pkg::RATIO_W-1:0]       cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [upr_pkg::VAL_W-1:0]         s_old_level,
    input  wire logic                              s_row_start,
    input  wire logic                              s_row_end,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [upr_pkg::VAL_W-1:0]              m_new_level,
    output logic                                   m_is_last,
    output logic                                   m_clamped
);

    upr_pkg::upr_state_t state_reg, state_next;

    logic [upr_pkg::RATIO_W-1:0]  ratio_reg;
    logic [upr_pkg::VAL_W-1:0]    prior_new_reg;
    logic [upr_pkg::VAL_W-1:0]    prior_old_reg;
    logic                         last_reg;
    logic                         flag_reg;

    logic                         m_valid_reg;
    logic [upr_pkg::VAL_W-1:0]    m_new_level_reg;
    logic                         m_is_last_reg;
    logic                         m_clamped_reg;

    logic                         accept;
    logic                         boundary;
    logic                         mac_start;
    logic                         mac_done;
    logic signed [upr_pkg::ACC_W-1:0] mac_acc;
    logic                         rad_neg;
    logic [upr_pkg::RAD_W-1:0]    rad;
    logic                         root_start;
    logic                         root_done;
    logic [upr_pkg::ROOT_W-1:0]   root;
    logic                         root_sat;
    logic [upr_pkg::VAL_W-1:0]    root_val;
    logic                         out_load;

    assign accept   = s_valid && s_ready;
    assign boundary = s_row_start || s_row_end;

    // negative radicand clamps to zero
    assign rad_neg = mac_acc[upr_pkg::ACC_W-1];
    assign rad     = rad_neg ? '0 : mac_acc[upr_pkg::RAD_W-1:0];

    // roots above the format saturate
    assign root_sat = |root[upr_pkg::ROOT_W-1:upr_pkg::VAL_W];
    assign root_val = root_sat ? {upr_pkg::VAL_W{1'b1}} : root[upr_pkg::VAL_W-1:0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            upr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = boundary ? upr_pkg::ST_DONE : upr_pkg::ST_MUL;
                end
            end
            upr_pkg::ST_MUL: begin
                if (mac_done) begin
                    state_next = upr_pkg::ST_ROOT;
                end
            end
            upr_pkg::ST_ROOT: begin
                if (root_done) begin
                    state_next = upr_pkg::ST_DONE;
                end
            end
            upr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = upr_pkg::ST_IDLE;
                end
            end
            default: state_next = upr_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready    = 1'b0;
        mac_start  = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            upr_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                mac_start = s_valid && !boundary;
            end
            upr_pkg::ST_MUL: begin
                root_start = mac_done;
            end
            upr_pkg::ST_ROOT: begin
            end
            upr_pkg::ST_DONE: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= upr_pkg::ST_IDLE;
            ratio_reg     <= upr_pkg::RATIO_RESET;
            prior_new_reg <= '0;
            prior_old_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                ratio_reg <= cfg_wr_data;
            end
            // the multiplier latches the prior values on mac_start
            if (accept) begin
                prior_old_reg <= s_old_level;
                if (boundary) begin
                    prior_new_reg <= s_old_level;
                end
            end
            if (state_reg == upr_pkg::ST_ROOT && root_done) begin
                prior_new_reg <= root_val;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item fields carried alongside the computation
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_reg <= s_row_end;
            flag_reg <= 1'b0;
        end else if (state_reg == upr_pkg::ST_MUL && mac_done) begin
            flag_reg <= rad_neg;
        end else if (state_reg == upr_pkg::ST_ROOT && root_done) begin
            flag_reg <= flag_reg || root_sat;
        end
        if (out_load) begin
            m_new_level_reg <= prior_new_reg;
            m_is_last_reg   <= last_reg;
            m_clamped_reg   <= flag_reg;
        end
    end

    upr_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mac_start),
        .prior_new (prior_new_reg),
        .prior_old (prior_old_reg),
        .ratio     (ratio_reg),
        .done      (mac_done),
        .acc       (mac_acc)
    );

    upr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .rad     (rad),
        .done    (root_done),
        .root    (root)
    );

    assign m_valid     = m_valid_reg;
    assign m_new_level = m_new_level_reg;
    assign m_is_last   = m_is_last_reg;
    assign m_clamped   = m_clamped_reg;

endmodule

`default_nettype wire

FILE: dv/upr_row_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the upwind row block, predicts each new level from
// its own copy of the ratio and previous-point state, and compares in order.
module upr_row_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [upr_pkg::RATIO_W-1:0]  cfg_wr_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [upr_pkg::VAL_W-1:0]    s_old_level,
    input  logic                         s_row_start,
    input  logic                         s_row_end,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [upr_pkg::VAL_W-1:0]    m_new_level,
    input  logic                         m_is_last,
    input  logic                         m_clamped,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen,
    output int                           clamps_seen
);
    import upr_pkg::*;

    typedef struct packed {
        logic [VAL_W-1:0] level;
        logic             last;
        logic             clamp;
    } point_t;

    localparam logic [VAL_W-1:0] LEVEL_MAX = '1;

    logic [RATIO_W-1:0] ratio;
    logic [VAL_W-1:0]   prev_new;
    logic [VAL_W-1:0]   prev_old;
    point_t             due_levels[$];
    point_t             want;

    // radicand stays below 2^39, so the root fits in 20 bits
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 23; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic point_t upwind_point(input logic [VAL_W-1:0] old_lvl,
                                            input logic st, input logic en);
        point_t      r;
        logic [63:0] sq;
        logic [63:0] drop;
        logic [63:0] rad;
        logic [63:0] root;
        logic [VAL_W-1:0] diff;
        r.last  = en;
        r.clamp = 1'b0;
        if (st || en) begin
            r.level = old_lvl;
        end else begin
            sq = 64'(prev_new) * 64'(prev_new);
            if (prev_new >= prev_old) begin
                diff = prev_new - prev_old;
                drop = 64'(ratio) * 64'(diff);
                if (drop > sq) begin
                    rad     = '0;
                    r.clamp = 1'b1;
                end else begin
                    rad = sq - drop;
                end
            end else begin
                diff = prev_old - prev_new;
                rad  = sq + 64'(ratio) * 64'(diff);
            end
            root = floor_root(rad);
            if (root > 64'(LEVEL_MAX)) begin
                r.level = LEVEL_MAX;
                r.clamp = 1'b1;
            end else begin
                r.level = root[VAL_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            ratio        = RATIO_RESET;
            prev_new     = '0;
            prev_old     = '0;
            due_levels.delete();
            pending      = 0;
            fail_count   = 0;
            results_seen = 0;
            clamps_seen  = 0;
        end else begin
            if (cfg_wr_en) ratio = cfg_wr_data;
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_levels.size() == 0) begin
                    report($sformatf("item %0d arrived with nothing expected, level %h",
                                     results_seen, m_new_level));
                end else begin
                    want = due_levels.pop_front();
                    if (m_new_level !== want.level)
                        report($sformatf("item %0d new_level %h, expected %h",
                                         results_seen, m_new_level, want.level));
                    if (m_is_last !== want.last)
                        report($sformatf("item %0d is_last %b, expected %b",
                                         results_seen, m_is_last, want.last));
                    if (m_clamped !== want.clamp)
                        report($sformatf("item %0d clamped %b, expected %b",
                                         results_seen, m_clamped, want.clamp));
                    if (want.clamp) clamps_seen++;
                end
            end
            if (s_valid && s_ready) begin
                want = upwind_point(s_old_level, s_row_start, s_row_end);
                due_levels.push_back(want);
                prev_new = want.level;
                prev_old = s_old_level;
            end
            pending = due_levels.size();
        end
    end

endmodule

FILE: dv/burgers_upwind_row_step_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the upwind row block. The checker instance does all
// prediction and comparison; this module only feeds points, writes the ratio
// between phases and decides pass or fail.
module burgers_upwind_row_step_test;
    import upr_pkg::*;

    localparam int               ITEMS_TARGET   = 850;
    // directed points plus row overshoot per phase take up the rest
    localparam int               PHASE_ITEMS    = (ITEMS_TARGET - 50) / 7;
    localparam int               WATCHDOG_LIMIT = 2000;
    localparam logic [VAL_W-1:0] LEVEL_MAX      = '1;
    localparam logic [RATIO_W-1:0] RATIO_MAX    = '1;

    // receiver stall styles
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_BLOCKS
    } rx_mode_t;

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [RATIO_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic [VAL_W-1:0]   s_old_level = '0;
    logic               s_row_start = 1'b0;
    logic               s_row_end   = 1'b0;
    logic               m_ready     = 1'b0;
    logic               s_ready;
    logic               m_valid;
    logic [VAL_W-1:0]   m_new_level;
    logic               m_is_last;
    logic               m_clamped;

    int fail_count;
    int pending;
    int results_seen;
    int clamps_seen;

    // sender bookkeeping
    int               burst_left = 0;
    int               sent_items = 0;
    int               cfg_writes = 0;
    bit               tx_on      = 1'b0;
    logic [VAL_W-1:0] last_level = '0;

    // receiver and watchdog
    rx_mode_t rx_mode     = RX_FREE;
    int       rx_cycle    = 0;
    int       rx_hold     = 0;
    int       quiet_count = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    burgers_upwind_row_step u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_old_level (s_old_level),
        .s_row_start (s_row_start),
        .s_row_end   (s_row_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_new_level (m_new_level),
        .m_is_last   (m_is_last),
        .m_clamped   (m_clamped)
    );

    upr_row_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_old_level  (s_old_level),
        .s_row_start  (s_row_start),
        .s_row_end    (s_row_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_new_level  (m_new_level),
        .m_is_last    (m_is_last),
        .m_clamped    (m_clamped),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .clamps_seen  (clamps_seen)
    );

    // Receiver: the stall style is redrawn at random from rx_cycle. Blocks mode
    // holds ready high or low until a random hold count runs down to zero.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_cycle <= 0;
            rx_hold  <= 0;
            rx_mode  <= RX_FREE;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 400 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
            case (rx_mode)
                RX_FREE: begin
                    m_ready <= 1'b1;
                end
                RX_COIN: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                RX_SPARSE: begin
                    m_ready <= ($urandom_range(0, 7) == 0);
                end
                default: begin
                    if (rx_hold == 0) begin
                        m_ready <= !m_ready;
                        rx_hold <= $urandom_range(0, 60);
                    end else begin
                        rx_hold <= rx_hold - 1;
                    end
                end
            endcase
        end
    end

    // Watchdog: a stretch with no item moving on either channel means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // Lower valid once, only if it is up. Called in the step of the last
    // handshake, so no other assignment to s_valid lands in that step.
    task automatic release_input();
        if (tx_on) begin
            s_valid <= 1'b0;
            tx_on = 1'b0;
        end
    endtask

    // Send one grid point. Bursts of random length; each burst starts after a
    // gap drawn at random, so gaps land on every phase of an item's computation.
    // Long bursts give stretches with no sender idling at all.
    task automatic push_point(input logic [VAL_W-1:0] lvl, input logic st,
                              input logic en);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 45);
            release_input();
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_old_level <= lvl;
        s_row_start <= st;
        s_row_end   <= en;
        tx_on = 1'b1;
        // ready is stable at the falling edge; accepted at the next rising one
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        sent_items++;
        last_level = lvl;
    endtask

    // Ratio writes only with the block idle: input released and every
    // expected item already delivered.
    task automatic set_ratio(input logic [RATIO_W-1:0] value);
        release_input();
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_writes++;
    endtask

    // Old level: extremes, full random, a smooth walk from the last point,
    // or small values where the negative radicand case lives.
    function automatic logic [VAL_W-1:0] pick_level(input logic [VAL_W-1:0] near);
        logic [31:0] r;
        int          v;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LEVEL_MAX;
            2, 3, 4: return r[VAL_W-1:0];
            5, 6, 7: begin
                v = int'(near) + $urandom_range(0, 2047) - 1024;
                if (v < 0) v = 0;
                if (v > int'(LEVEL_MAX)) v = int'(LEVEL_MAX);
                return v[VAL_W-1:0];
            end
            default: return r[7:0];
        endcase
    endfunction

    // One well-formed row: start marker first, end marker last. A length of
    // one puts both markers on the same point.
    task automatic send_row(input int len);
        for (int i = 0; i < len; i++)
            push_point(pick_level(last_level), i == 0, i == len - 1);
    endtask

    initial begin
        logic [RATIO_W-1:0] next_ratio;
        int                 phase_base;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed, default ratio 0.2 ---
        // inner point straight after reset runs on the zero state
        push_point(17'h00123, 1'b0, 1'b0);
        // full row from the top value down to zero
        push_point(LEVEL_MAX, 1'b1, 1'b0);
        push_point(17'h1FFF0, 1'b0, 1'b0);
        push_point(17'h10000, 1'b0, 1'b0);
        push_point('0, 1'b0, 1'b1);
        // both markers on one point
        push_point(17'h0AAAA, 1'b1, 1'b1);
        // small start then a drop to zero: radicand goes negative, clamps
        push_point(17'd100, 1'b1, 1'b0);
        push_point('0, 1'b0, 1'b0);
        push_point(17'd5, 1'b0, 1'b0);
        push_point(17'd7, 1'b0, 1'b1);
        // inner point with no start: carries the previous row's last point
        push_point(17'h15555, 1'b0, 1'b0);

        // ratio zero: each inner point repeats the previous new value
        set_ratio('0);
        push_point(17'h08000, 1'b1, 1'b0);
        push_point(LEVEL_MAX, 1'b0, 1'b0);
        push_point('0, 1'b0, 1'b0);
        push_point(17'd1, 1'b0, 1'b1);

        // largest ratio: zero new against a full old value saturates
        set_ratio(RATIO_MAX);
        push_point('0, 1'b1, 1'b0);
        push_point(LEVEL_MAX, 1'b0, 1'b0);
        push_point('0, 1'b0, 1'b0);
        push_point(LEVEL_MAX, 1'b0, 1'b1);

        // --- random phases, one ratio per phase, extremes included ---
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: next_ratio = RATIO_RESET;
                1: next_ratio = RATIO_W'($urandom_range(0, 65535));
                2: next_ratio = 20'd1;
                3: next_ratio = RATIO_W'($urandom);
                4: next_ratio = RATIO_MAX;
                5: next_ratio = '0;
                default: next_ratio = RATIO_W'($urandom_range(1, 1 << 18));
            endcase
            set_ratio(next_ratio);
            phase_base = sent_items;
            while (sent_items - phase_base < PHASE_ITEMS) begin
                // mostly short rows, now and then a long one
                send_row(($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                     : $urandom_range(1, 12));
                // occasional stray point with arbitrary markers
                if ($urandom_range(0, 5) == 0)
                    push_point(pick_level(last_level), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
            end
        end

        // drain, then allow a root's worth of cycles for strays
        release_input();
        do @(negedge aclk); while (pending != 0);
        repeat (60) @(posedge aclk);

        $display("%0d grid points over %0d ratio settings, %0d items checked",
                 sent_items, cfg_writes + 1, results_seen);
        $display("%0d items took the clamp or saturation path", clamps_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
